### rtl/sobel_gradient_magnitude_defines.svh
// Assertion macros shared by the Sobel gradient magnitude RTL.
`ifndef SOBEL_GRADIENT_MAGNITUDE_DEFINES_SVH
`define SOBEL_GRADIENT_MAGNITUDE_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define SGM_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define SGM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/sgm_pkg.sv
// Types, constants and codes shared by the Sobel gradient magnitude block.
`default_nettype none
package sgm_pkg;

    localparam int PIX_W          = 8;
    localparam int CFG_W          = 10;
    localparam int CFG_INDEX_W    = 1;
    localparam int COORD_W        = 9;
    localparam int DEF_MAX_WIDTH  = 512;
    localparam int DEF_MAX_HEIGHT = 512;
    localparam int MIN_SIZE       = 2;
    localparam logic [CFG_W-1:0] SIZE_RESET = 10'd512;

    localparam int GRAY_SUM_W = 13;
    localparam int GRAY_SHIFT = 5;
    localparam int GRAY_R     = 11;
    localparam int GRAY_G     = 16;
    localparam int GRAY_B     = 5;

    localparam int GRAD_W     = 12;
    localparam int SQ_W       = 20;
    localparam int SUM_W      = 21;
    localparam int ROOT_IN_W  = 16;
    localparam int ROOT_BIT_W = 3;
    localparam logic [PIX_W-1:0] MAG_MAX = 8'd255;

    localparam int JOB_N          = 4;
    localparam int JOB_UPPER_PREV = 0;
    localparam int JOB_UPPER_LAST = 1;
    localparam int JOB_LOWER_PREV = 2;
    localparam int JOB_LOWER_LAST = 3;

    typedef logic [JOB_N-1:0] job_mask_t;

    // [row top..bottom][column left..right]
    typedef logic [2:0][2:0][PIX_W-1:0] win_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_WIDTH  = 1'b0,
        CFG_HEIGHT = 1'b1
    } cfg_index_t;

    typedef struct packed {
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
    } in_word_t;

    typedef struct packed {
        logic [COORD_W-1:0] out_column;
        logic [COORD_W-1:0] out_row;
        logic [PIX_W-1:0]   magnitude;
        logic               last_of_run;
    } out_word_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FETCH,
        ST_DISPATCH,
        ST_CALC,
        ST_EMIT
    } sgm_state_t;

    typedef enum logic [2:0] {
        MG_IDLE,
        MG_GRAD,
        MG_SQUARE,
        MG_SUM,
        MG_ROOT
    } mag_state_t;

endpackage
`default_nettype wire

### rtl/sobel_gradient_magnitude.sv
// Top level of the streaming 3x3 Sobel gradient magnitude block.
// RGB pixels enter in raster order and are turned to gray; two line stores
// (single read-modify-write per pixel) and a 3x3 window with edge
// replication give the neighbourhood. Results for a pixel appear one row and
// one column later, the last row and column as soon as their last pixel is
// in. A pixel is accepted, reading the line stores, then written back;
// each result it causes (0 to 4) goes through the magnitude unit and its
// bit-serial square root, skipped for a magnitude that saturates. The next
// pixel is taken while the last result still waits on the output word. The
// user must write width and height only while idle, which is not enforced.
`default_nettype none
`include "sobel_gradient_magnitude_defines.svh"
module sobel_gradient_magnitude
    import sgm_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_valid,
    output logic                        s_ready,
    input  wire in_word_t               s_data,
    output logic                        m_valid,
    input  wire logic                   m_ready,
    output out_word_t                   m_data,
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]       cfg_data
);

    localparam int CW   = $clog2(MAX_WIDTH);
    localparam int RW   = $clog2(MAX_HEIGHT);
    localparam int SZ_A = (CW > RW) ? CW + 1 : RW + 1;
    localparam int SZW  = (SZ_A > CFG_W) ? SZ_A : CFG_W;
    localparam logic [SZW-1:0] W_MAX = SZW'(MAX_WIDTH);
    localparam logic [SZW-1:0] H_MAX = SZW'(MAX_HEIGHT);

    sgm_state_t state_reg, state_next;

    logic [CFG_W-1:0]    width_reg, height_reg;
    logic [CW-1:0]       col_count_reg, cur_col_reg;
    logic [RW-1:0]       row_count_reg, cur_row_reg;
    logic [PIX_W-1:0]    gray_reg, rd_prev_reg, rd_prev2_reg;
    logic [PIX_W-1:0]    top, mid;
    logic [GRAY_SUM_W-1:0] gray_sum;
    win_t                win_reg, view;
    logic [2:0][2:0][PIX_W-1:0] rows_sel;
    job_mask_t           mask_reg, job_onehot, mask_fetch;
    logic                job_lower, job_last_col, left_edge;
    logic [SZW-1:0]      w_raw, h_raw, w_eff, h_eff;
    logic                last_col, last_row, row_nz, col_nz;
    logic                in_accept, out_free, out_load, mag_start, mag_done;
    logic [PIX_W-1:0]    mag;
    logic                m_valid_reg;
    out_word_t           m_data_reg, out_word;

    logic [PIX_W-1:0] prev_mem  [MAX_WIDTH];
    logic [PIX_W-1:0] prev2_mem [MAX_WIDTH];

    assign cfg_ready = 1'b1;
    assign in_accept = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;

    // active size, clamped
    assign w_raw = SZW'(width_reg);
    assign h_raw = SZW'(height_reg);
    always_comb begin
        if (w_raw < SZW'(MIN_SIZE)) begin
            w_eff = SZW'(MIN_SIZE);
        end else if (w_raw > W_MAX) begin
            w_eff = W_MAX;
        end else begin
            w_eff = w_raw;
        end
        if (h_raw < SZW'(MIN_SIZE)) begin
            h_eff = SZW'(MIN_SIZE);
        end else if (h_raw > H_MAX) begin
            h_eff = H_MAX;
        end else begin
            h_eff = h_raw;
        end
    end

    assign last_col = (SZW'(cur_col_reg) + SZW'(1)) >= w_eff;
    assign last_row = (SZW'(cur_row_reg) + SZW'(1)) >= h_eff;
    assign row_nz   = cur_row_reg != '0;
    assign col_nz   = cur_col_reg != '0;

    assign gray_sum = GRAY_SUM_W'(s_data.red) * GRAY_SUM_W'(GRAY_R)
                    + GRAY_SUM_W'(s_data.green) * GRAY_SUM_W'(GRAY_G)
                    + GRAY_SUM_W'(s_data.blue) * GRAY_SUM_W'(GRAY_B);

    always_comb begin
        if (!row_nz) begin
            mid = gray_reg;
            top = gray_reg;
        end else begin
            mid = rd_prev_reg;
            top = (cur_row_reg >= RW'(MIN_SIZE)) ? rd_prev2_reg : rd_prev_reg;
        end
    end

    always_comb begin
        mask_fetch                 = '0;
        mask_fetch[JOB_UPPER_PREV] = row_nz && col_nz;
        mask_fetch[JOB_UPPER_LAST] = row_nz && last_col;
        mask_fetch[JOB_LOWER_PREV] = row_nz && last_row && col_nz;
        mask_fetch[JOB_LOWER_LAST] = row_nz && last_row && last_col;
    end

    // lowest pending result first
    assign job_onehot   = mask_reg & (~mask_reg + JOB_N'(1));
    assign job_lower    = job_onehot[JOB_LOWER_PREV] | job_onehot[JOB_LOWER_LAST];
    assign job_last_col = job_onehot[JOB_UPPER_LAST] | job_onehot[JOB_LOWER_LAST];
    assign left_edge    = cur_col_reg < CW'(MIN_SIZE);

    always_comb begin
        rows_sel[0] = job_lower ? win_reg[1] : win_reg[0];
        rows_sel[1] = job_lower ? win_reg[2] : win_reg[1];
        rows_sel[2] = win_reg[2];
        for (int i = 0; i < 3; i++) begin
            if (job_last_col) begin
                view[i][0] = rows_sel[i][1];
                view[i][1] = rows_sel[i][2];
                view[i][2] = rows_sel[i][2];
            end else begin
                view[i][0] = left_edge ? rows_sel[i][1] : rows_sel[i][0];
                view[i][1] = rows_sel[i][1];
                view[i][2] = rows_sel[i][2];
            end
        end
    end

    always_comb begin
        out_word.out_column  = job_last_col ? COORD_W'(cur_col_reg)
                                            : COORD_W'(cur_col_reg - CW'(1));
        out_word.out_row     = job_lower ? COORD_W'(cur_row_reg)
                                         : COORD_W'(cur_row_reg - RW'(1));
        out_word.magnitude   = mag;
        out_word.last_of_run = (mask_reg & ~job_onehot) == '0;
    end

    always_comb begin
        state_next = state_reg;
        s_ready    = 1'b0;
        mag_start  = 1'b0;
        out_load   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    state_next = ST_FETCH;
                end
            end
            ST_FETCH: state_next = ST_DISPATCH;
            ST_DISPATCH: begin
                if (mask_reg != '0) begin
                    mag_start  = 1'b1;
                    state_next = ST_CALC;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_CALC: begin
                if (mag_done) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    state_next = ST_DISPATCH;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            width_reg     <= SIZE_RESET;
            height_reg    <= SIZE_RESET;
            col_count_reg <= '0;
            row_count_reg <= '0;
            win_reg       <= '0;
            mask_reg      <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_valid) begin
                case (cfg_index)
                    CFG_WIDTH:  width_reg  <= cfg_data;
                    CFG_HEIGHT: height_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (state_reg == ST_FETCH) begin
                for (int k = 0; k < 3; k++) begin
                    win_reg[k][0] <= win_reg[k][1];
                    win_reg[k][1] <= win_reg[k][2];
                end
                win_reg[0][2] <= top;
                win_reg[1][2] <= mid;
                win_reg[2][2] <= gray_reg;
                mask_reg      <= mask_fetch;
                if (last_col) begin
                    col_count_reg <= '0;
                    row_count_reg <= last_row ? '0 : row_count_reg + RW'(1);
                end else begin
                    col_count_reg <= col_count_reg + CW'(1);
                end
            end else if (out_load) begin
                mask_reg <= mask_reg & ~job_onehot;
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_accept) begin
            cur_col_reg <= col_count_reg;
            cur_row_reg <= row_count_reg;
            gray_reg    <= gray_sum[GRAY_SUM_W-1:GRAY_SHIFT];
        end
        if (out_load) begin
            m_data_reg <= out_word;
        end
    end

    // line stores: read on accept, written back in the fetch cycle; the next
    // read comes after the write, so no forwarding
    always_ff @(posedge aclk) begin
        if (in_accept) begin
            rd_prev_reg <= prev_mem[col_count_reg];
        end
        if (state_reg == ST_FETCH) begin
            prev_mem[cur_col_reg] <= gray_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_accept) begin
            rd_prev2_reg <= prev2_mem[col_count_reg];
        end
        if ((state_reg == ST_FETCH) && row_nz) begin
            prev2_mem[cur_col_reg] <= rd_prev_reg;
        end
    end

    sgm_magnitude u_mag (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mag_start),
        .view    (view),
        .done    (mag_done),
        .mag     (mag)
    );

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    `SGM_ASSERT_NEXT(a_accept_fetch, aclk, aresetn, in_accept, state_reg == ST_FETCH, "accept not followed by fetch")
    `SGM_ASSERT_IMPL(a_idle_no_jobs, aclk, aresetn, s_ready, mask_reg == '0, "pixel taken with results pending")
    `SGM_ASSERT_IMPL(a_start_has_job, aclk, aresetn, mag_start, mask_reg != '0, "magnitude started with no job")
    `SGM_ASSERT_IMPL(a_col_in_range, aclk, aresetn, 1'b1, SZW'(col_count_reg) < W_MAX, "column beyond store")

endmodule
`default_nettype wire

### rtl/sgm_magnitude.sv
// Sobel gradient, sum of squares and bit-serial integer square root.
`default_nettype none
`include "sobel_gradient_magnitude_defines.svh"
module sgm_magnitude
    import sgm_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       start,
    input  wire win_t       view,
    output logic            done,
    output logic [PIX_W-1:0] mag
);

    mag_state_t state_reg, state_next;

    win_t                        view_reg;
    logic signed [GRAD_W-1:0]    gx_reg, gy_reg, gx_next, gy_next;
    logic signed [2*GRAD_W-1:0]  prod_x, prod_y;
    logic [SQ_W-1:0]             gx2_reg, gy2_reg;
    logic [SUM_W-1:0]            sum;
    logic [ROOT_IN_W-1:0]        rad_reg;
    logic [PIX_W-1:0]            root_reg, trial;
    logic [2*PIX_W-1:0]          trial_sq;
    logic [ROOT_BIT_W-1:0]       bit_reg;
    logic                        done_reg;

    function automatic logic signed [GRAD_W-1:0] px(input logic [PIX_W-1:0] p);
        px = signed'(GRAD_W'(p));
    endfunction

    always_comb begin
        gx_next = (px(view_reg[0][2]) - px(view_reg[0][0]))
                + ((px(view_reg[1][2]) - px(view_reg[1][0])) <<< 1)
                + (px(view_reg[2][2]) - px(view_reg[2][0]));
        gy_next = (px(view_reg[2][0]) - px(view_reg[0][0]))
                + ((px(view_reg[2][1]) - px(view_reg[0][1])) <<< 1)
                + (px(view_reg[2][2]) - px(view_reg[0][2]));
    end

    assign prod_x   = gx_reg * gx_reg;
    assign prod_y   = gy_reg * gy_reg;
    assign sum      = SUM_W'(gx2_reg) + SUM_W'(gy2_reg);
    assign trial    = root_reg | (PIX_W'(1) << bit_reg);
    assign trial_sq = trial * trial;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            MG_IDLE: begin
                if (start) begin
                    state_next = MG_GRAD;
                end
            end
            MG_GRAD:   state_next = MG_SQUARE;
            MG_SQUARE: state_next = MG_SUM;
            MG_SUM: begin
                if (sum[SUM_W-1:ROOT_IN_W] != '0) begin
                    state_next = MG_IDLE;
                end else begin
                    state_next = MG_ROOT;
                end
            end
            MG_ROOT: begin
                if (bit_reg == '0) begin
                    state_next = MG_IDLE;
                end
            end
            default: state_next = MG_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= MG_IDLE;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= ((state_reg == MG_SUM) && (state_next == MG_IDLE))
                      || ((state_reg == MG_ROOT) && (bit_reg == '0));
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            MG_IDLE: begin
                if (start) begin
                    view_reg <= view;
                end
            end
            MG_GRAD: begin
                gx_reg <= gx_next;
                gy_reg <= gy_next;
            end
            MG_SQUARE: begin
                gx2_reg <= prod_x[SQ_W-1:0];
                gy2_reg <= prod_y[SQ_W-1:0];
            end
            MG_SUM: begin
                rad_reg  <= sum[ROOT_IN_W-1:0];
                bit_reg  <= ROOT_BIT_W'(PIX_W - 1);
                root_reg <= (sum[SUM_W-1:ROOT_IN_W] != '0) ? MAG_MAX : '0;
            end
            MG_ROOT: begin
                if (trial_sq <= rad_reg) begin
                    root_reg <= trial;
                end
                bit_reg <= bit_reg - ROOT_BIT_W'(1);
            end
            default: ;
        endcase
    end

    assign done = done_reg;
    assign mag  = root_reg;

    `SGM_ASSERT_IMPL(a_start_when_idle, aclk, aresetn, start, state_reg == MG_IDLE, "start while busy")
    `SGM_ASSERT_NEXT(a_done_pulse, aclk, aresetn, done_reg, !done_reg, "done held over two cycles")

endmodule
`default_nettype wire
